[sv/cststf_pkg.sv]
// shared constants and types of the triangle stiffness block
// no dependencies; used by cststf_div and cst_triangle_stiffness
`timescale 1ns / 1ps
`default_nettype none
package cststf_pkg;

    localparam int COORD_W   = 32;
    localparam int DIFF_W    = 33;
    localparam int PROD_W    = 66;
    localparam int DET_W     = 67;
    localparam int ADET_W    = 66;
    localparam int HALF_W    = 33;
    localparam int F_W       = 33;
    localparam int DEN_W     = 98;
    localparam int KCOEF_W   = 18;
    localparam int WM_W      = 50;
    localparam int WLO_W     = 25;
    localparam int WHI_W     = WM_W - WLO_W;
    localparam int PLO_W     = DIFF_W + WLO_W + 1;
    localparam int PHI_W     = DIFF_W + WHI_W;
    localparam int S_W       = 83;
    localparam int AS_W      = 82;
    localparam int LIMB_W    = 28;
    localparam int NLIMB     = 3;
    localparam int TE_W      = 64;
    localparam int TLIMB_W   = 32;
    localparam int NTLIMB    = 2;
    localparam int PP_W      = LIMB_W + TLIMB_W;
    localparam int N_W       = 146;
    localparam int Q_W       = 64;
    localparam int EXTRA_SH  = 22;
    localparam int DIV_STEPS = Q_W;
    localparam int DIV_LAT   = DIV_STEPS + 3;
    localparam int ROWS      = 6;
    localparam int COLS      = 6;
    localparam int ROW_W     = 3;
    localparam int YM_W      = 32;
    localparam int PR_W      = 15;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DW    = 32;
    localparam int S_TDATA_W = 224;
    localparam int M_TDATA_W = 392;

    localparam logic [ROW_W-1:0] ROW_LAST = 3'd5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_YOUNGS  = 1'b0,
        CFG_POISSON = 1'b1
    } cfg_reg_t;

    // control that rides along with each row in flight
    typedef struct packed {
        logic             vld;
        logic [ROW_W-1:0] row;
        logic             degen;
    } side_t;

endpackage
`default_nettype wire

[sv/cststf_div.sv]
// one lane of the pipelined restoring divider with rounding and saturation
// depends on cststf_pkg
`timescale 1ns / 1ps
`default_nettype none
module cststf_div (
    input  wire logic                          aclk,
    input  wire logic                          en,
    input  wire logic [cststf_pkg::N_W-1:0]    num_i,
    input  wire logic [cststf_pkg::DEN_W-1:0]  den_i,
    input  wire logic                          neg_i,
    output logic [cststf_pkg::Q_W-1:0]         val_o
);
    localparam int NW  = cststf_pkg::N_W;
    localparam int DW  = cststf_pkg::DEN_W;
    localparam int QW  = cststf_pkg::Q_W;
    localparam int NS  = cststf_pkg::DIV_STEPS;
    localparam int OSH = QW - cststf_pkg::EXTRA_SH;
    localparam int HW  = NW - OSH;

    logic [DW-1:0] rem_reg [NS+1];
    logic [QW-1:0] low_reg [NS+1];
    logic [QW-1:0] quo_reg [NS+1];
    logic [DW-1:0] den_reg [NS+1];
    logic          neg_reg [NS+1];
    logic          ovf_reg [NS+1];

    logic [HW-1:0] hi;
    logic          ovf;
    assign hi  = num_i[NW-1:OSH];
    assign ovf = hi >= {{(HW-DW){1'b0}}, den_i};

    // quotient beyond 64 bits saturates anyway
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= ovf ? '0 : hi[DW-1:0];
            low_reg[0] <= {num_i[OSH-1:0], {cststf_pkg::EXTRA_SH{1'b0}}};
            quo_reg[0] <= '0;
            den_reg[0] <= den_i;
            neg_reg[0] <= neg_i;
            ovf_reg[0] <= ovf;
        end
    end

    for (genvar k = 0; k < NS; k++) begin : g_step
        logic [DW-1:0] trial;
        logic          ge;
        assign trial = {rem_reg[k][DW-2:0], low_reg[k][QW-1]};
        assign ge    = trial >= den_reg[k];
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1] <= ge ? trial - den_reg[k] : trial;
                low_reg[k+1] <= {low_reg[k][QW-2:0], 1'b0};
                quo_reg[k+1] <= {quo_reg[k][QW-2:0], ge};
                den_reg[k+1] <= den_reg[k];
                neg_reg[k+1] <= neg_reg[k];
                ovf_reg[k+1] <= ovf_reg[k];
            end
        end
    end

    // round half up on the magnitude
    logic [QW:0] qr_reg;
    logic        rneg_reg;
    logic        rovf_reg;
    logic        up;
    assign up = {rem_reg[NS], 1'b0} >= {1'b0, den_reg[NS]};

    always_ff @(posedge aclk) begin
        if (en) begin
            qr_reg   <= {1'b0, quo_reg[NS]} + {{QW{1'b0}}, up};
            rneg_reg <= neg_reg[NS];
            rovf_reg <= ovf_reg[NS];
        end
    end

    localparam logic [QW:0]   POS_MAX = {2'b00, {(QW-1){1'b1}}};
    localparam logic [QW:0]   NEG_MAX = {2'b01, {(QW-1){1'b0}}};
    localparam logic [QW-1:0] SAT_POS = {1'b0, {(QW-1){1'b1}}};
    localparam logic [QW-1:0] SAT_NEG = {1'b1, {(QW-1){1'b0}}};

    logic [QW-1:0] val_reg;
    logic [QW-1:0] val_next;

    always_comb begin
        if (rneg_reg) begin
            val_next = (rovf_reg || qr_reg > NEG_MAX) ? SAT_NEG : -qr_reg[QW-1:0];
        end else begin
            val_next = (rovf_reg || qr_reg > POS_MAX) ? SAT_POS : qr_reg[QW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            val_reg <= val_next;
        end
    end

    assign val_o = val_reg;
endmodule
`default_nettype wire

[sv/cst_triangle_stiffness.sv]
// top level: plane-stress stiffness matrix of the constant strain triangle
// depends on cststf_pkg and cststf_div
`timescale 1ns / 1ps
`default_nettype none
// One input word carries a triangle (three Q16.16 corners and a Q16.16
// thickness); the block answers with six output words, rows u1 v1 u2 v2 u3 v3
// of K = area * B^T D B in saturated Q32.32, with tlast on the sixth row and
// tuser set when the triangle has zero area (its rows are then all zero).
// A new triangle is accepted as the last row of the previous one is issued;
// the output channel moves one row per cycle unless m_tready holds it, and
// each triangle needs six rows. Rows pass six arithmetic stages, then a
// divider that registers its first remainder, resolves one quotient bit per
// stage over 64 stages, then rounding and saturation. Young's modulus (Q24.8)
// and Poisson's ratio (Q0.16) are to be written through the configuration
// port only while no triangle is in flight; the block does not enforce this.
module cst_triangle_stiffness (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire logic                                    cfg_wr_en,
    input  wire logic [cststf_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [cststf_pkg::CFG_DW-1:0]           cfg_wdata,
    input  wire logic                                    s_tvalid,
    output logic                                         s_tready,
    // x_first, y_first, x_second, y_second, x_third, y_third, plate_thickness
    input  wire logic [cststf_pkg::S_TDATA_W-1:0]        s_tdata,
    output logic                                         m_tvalid,
    input  wire logic                                    m_tready,
    // row_index, col0, col1, col2, col3, col4, col5, zero pad
    output logic [cststf_pkg::M_TDATA_W-1:0]             m_tdata,
    output logic                                         m_tlast,
    // degenerate
    output logic                                         m_tuser
);
    localparam int CW  = cststf_pkg::COORD_W;
    localparam int DFW = cststf_pkg::DIFF_W;
    localparam int WMW = cststf_pkg::WM_W;
    localparam int KW  = cststf_pkg::KCOEF_W;
    localparam int NC  = cststf_pkg::COLS;
    localparam int LAT = cststf_pkg::DIV_LAT;

    // ---------------------------------------------------------------- config
    logic [cststf_pkg::YM_W-1:0] ym_reg;
    logic [cststf_pkg::PR_W-1:0] pr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ym_reg <= '0;
            pr_reg <= '0;
        end else if (cfg_wr_en) begin
            if (cfg_index == cststf_pkg::CFG_YOUNGS) begin
                ym_reg <= cfg_wdata;
            end else if (cfg_index == cststf_pkg::CFG_POISSON) begin
                pr_reg <= cfg_wdata[cststf_pkg::PR_W-1:0];
            end
        end
    end

    // ------------------------------------------------------- pipeline enable
    // the whole pipeline moves together; it holds while the output word waits
    cststf_pkg::side_t out_side;
    logic              en;
    assign en = !out_side.vld || m_tready;

    // ----------------------------------------------------- triangle holding
    logic signed [CW-1:0]   xy_reg [6];
    logic [CW-1:0]          t_reg;
    logic                   tri_vld_reg;
    logic [cststf_pkg::ROW_W-1:0] row_cnt_reg;
    logic                   issue;
    logic                   accept;

    assign issue    = tri_vld_reg && en;
    assign s_tready = !tri_vld_reg || (en && row_cnt_reg == cststf_pkg::ROW_LAST);
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tri_vld_reg <= 1'b0;
            row_cnt_reg <= '0;
        end else if (accept) begin
            tri_vld_reg <= 1'b1;
            row_cnt_reg <= '0;
        end else if (issue && row_cnt_reg == cststf_pkg::ROW_LAST) begin
            tri_vld_reg <= 1'b0;
        end else if (issue) begin
            row_cnt_reg <= row_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            for (int i = 0; i < 6; i++) begin
                xy_reg[i] <= s_tdata[i*CW +: CW];
            end
            t_reg <= s_tdata[6*CW +: CW];
        end
    end

    // ---------------------------------------------- stage 1: edge vectors
    // b = y differences, c = x differences, per corner
    cststf_pkg::side_t      s1_side_reg;
    logic signed [DFW-1:0]  s1_b_reg [3];
    logic signed [DFW-1:0]  s1_c_reg [3];
    logic [CW-1:0]          s1_t_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_side_reg <= '0;
        end else if (en) begin
            s1_side_reg.vld   <= tri_vld_reg;
            s1_side_reg.row   <= row_cnt_reg;
            s1_side_reg.degen <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_b_reg[0] <= DFW'(xy_reg[3]) - DFW'(xy_reg[5]);
            s1_b_reg[1] <= DFW'(xy_reg[5]) - DFW'(xy_reg[1]);
            s1_b_reg[2] <= DFW'(xy_reg[1]) - DFW'(xy_reg[3]);
            s1_c_reg[0] <= DFW'(xy_reg[4]) - DFW'(xy_reg[2]);
            s1_c_reg[1] <= DFW'(xy_reg[0]) - DFW'(xy_reg[4]);
            s1_c_reg[2] <= DFW'(xy_reg[2]) - DFW'(xy_reg[0]);
            s1_t_reg    <= t_reg;
        end
    end

    // --------------------------------- stage 2: area terms, D times B columns
    function automatic logic signed [WMW-1:0] scl(input logic signed [DFW-1:0] v,
                                                  input logic [KW-1:0] k);
        logic signed [DFW+KW:0] pr;
        pr = v * $signed({1'b0, k});
        return pr[WMW-1:0];
    endfunction

    cststf_pkg::side_t                    s2_side_reg;
    logic signed [cststf_pkg::PROD_W-1:0] s2_cba_reg;
    logic signed [cststf_pkg::PROD_W-1:0] s2_cbb_reg;
    logic [cststf_pkg::F_W-1:0]           s2_f_reg;
    logic [cststf_pkg::TE_W-1:0]          s2_te_reg;
    logic signed [DFW-1:0]                s2_x_reg;
    logic signed [DFW-1:0]                s2_y_reg;
    logic signed [WMW-1:0]                s2_wa_reg [NC];
    logic signed [WMW-1:0]                s2_wb_reg [NC];

    logic [KW-1:0]            k_diag;
    logic [KW-1:0]            k_off;
    logic [KW-1:0]            k_shear;
    logic [29:0]              p_sq;
    logic [cststf_pkg::F_W-1:0] f_next;
    logic [1:0]               node;
    logic                     odd_row;
    logic signed [DFW-1:0]    x_next;
    logic signed [DFW-1:0]    y_next;
    logic signed [WMW-1:0]    wa_next [NC];
    logic signed [WMW-1:0]    wb_next [NC];

    always_comb begin
        k_diag  = KW'(1 << 17);
        k_off   = {2'b00, pr_reg, 1'b0};
        k_shear = KW'(1 << 16) - {3'b000, pr_reg};
        p_sq    = pr_reg * pr_reg;
        f_next  = {1'b1, 32'h0} - {3'b000, p_sq};
        node    = s1_side_reg.row[2:1];
        odd_row = s1_side_reg.row[0];
        // even rows pair b with D row 0 and c with the shear row,
        // odd rows pair c with D row 1 and b with the shear row
        x_next  = odd_row ? s1_c_reg[node] : s1_b_reg[node];
        y_next  = odd_row ? s1_b_reg[node] : s1_c_reg[node];
        for (int j = 0; j < NC; j++) begin
            if (j % 2 == 0) begin
                wa_next[j] = odd_row ? scl(s1_b_reg[j/2], k_off)
                                     : scl(s1_b_reg[j/2], k_diag);
                wb_next[j] = scl(s1_c_reg[j/2], k_shear);
            end else begin
                wa_next[j] = odd_row ? scl(s1_c_reg[j/2], k_diag)
                                     : scl(s1_c_reg[j/2], k_off);
                wb_next[j] = scl(s1_b_reg[j/2], k_shear);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_side_reg <= '0;
        end else if (en) begin
            s2_side_reg <= s1_side_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_cba_reg <= s1_c_reg[2] * s1_b_reg[1];
            s2_cbb_reg <= s1_c_reg[1] * s1_b_reg[2];
            s2_f_reg   <= f_next;
            s2_te_reg  <= s1_t_reg * ym_reg;
            s2_x_reg   <= x_next;
            s2_y_reg   <= y_next;
            for (int j = 0; j < NC; j++) begin
                s2_wa_reg[j] <= wa_next[j];
                s2_wb_reg[j] <= wb_next[j];
            end
        end
    end

    // ------------------------------ stage 3: area, split products of B^T D B
    localparam int LO = cststf_pkg::WLO_W;

    cststf_pkg::side_t                     s3_side_reg;
    logic [cststf_pkg::ADET_W-1:0]         s3_adet_reg;
    logic [cststf_pkg::F_W-1:0]            s3_f_reg;
    logic [cststf_pkg::TE_W-1:0]           s3_te_reg;
    logic signed [cststf_pkg::PLO_W-1:0]   s3_xl_reg [NC];
    logic signed [cststf_pkg::PHI_W-1:0]   s3_xh_reg [NC];
    logic signed [cststf_pkg::PLO_W-1:0]   s3_yl_reg [NC];
    logic signed [cststf_pkg::PHI_W-1:0]   s3_yh_reg [NC];

    logic signed [cststf_pkg::DET_W-1:0]   det;
    logic signed [cststf_pkg::DET_W-1:0]   adet_full;

    always_comb begin
        det       = cststf_pkg::DET_W'(s2_cba_reg) - cststf_pkg::DET_W'(s2_cbb_reg);
        adet_full = det[cststf_pkg::DET_W-1] ? -det : det;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_side_reg <= '0;
        end else if (en) begin
            s3_side_reg.vld   <= s2_side_reg.vld;
            s3_side_reg.row   <= s2_side_reg.row;
            s3_side_reg.degen <= (det == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_adet_reg <= adet_full[cststf_pkg::ADET_W-1:0];
            s3_f_reg    <= s2_f_reg;
            s3_te_reg   <= s2_te_reg;
            for (int j = 0; j < NC; j++) begin
                s3_xl_reg[j] <= s2_x_reg * $signed({1'b0, s2_wa_reg[j][LO-1:0]});
                s3_xh_reg[j] <= s2_x_reg * $signed(s2_wa_reg[j][WMW-1:LO]);
                s3_yl_reg[j] <= s2_y_reg * $signed({1'b0, s2_wb_reg[j][LO-1:0]});
                s3_yh_reg[j] <= s2_y_reg * $signed(s2_wb_reg[j][WMW-1:LO]);
            end
        end
    end

    // --------------------------- stage 4: entry sums, denominator partials
    localparam int SW  = cststf_pkg::S_W;
    localparam int HFW = cststf_pkg::HALF_W;

    cststf_pkg::side_t                 s4_side_reg;
    logic [cststf_pkg::AS_W-1:0]       s4_as_reg [NC];
    logic                              s4_neg_reg [NC];
    logic [2*HFW-1:0]                  s4_dlo_reg;
    logic [2*HFW-1:0]                  s4_dhi_reg;
    logic [cststf_pkg::TE_W-1:0]       s4_te_reg;

    logic signed [SW-1:0] s_sum [NC];
    logic signed [SW-1:0] s_abs [NC];

    always_comb begin
        for (int j = 0; j < NC; j++) begin
            s_sum[j] = SW'(s3_xl_reg[j]) + (SW'(s3_xh_reg[j]) <<< LO)
                     + SW'(s3_yl_reg[j]) + (SW'(s3_yh_reg[j]) <<< LO);
            s_abs[j] = s_sum[j][SW-1] ? -s_sum[j] : s_sum[j];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_side_reg <= '0;
        end else if (en) begin
            s4_side_reg <= s3_side_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < NC; j++) begin
                s4_as_reg[j]  <= s_abs[j][cststf_pkg::AS_W-1:0];
                s4_neg_reg[j] <= s_sum[j][SW-1];
            end
            s4_dlo_reg <= s3_adet_reg[HFW-1:0] * s3_f_reg;
            s4_dhi_reg <= s3_adet_reg[2*HFW-1:HFW] * s3_f_reg;
            s4_te_reg  <= s3_te_reg;
        end
    end

    // ---------------------- stage 5: denominator, numerator partial products
    localparam int DW  = cststf_pkg::DEN_W;
    localparam int LW  = cststf_pkg::LIMB_W;
    localparam int TLW = cststf_pkg::TLIMB_W;
    localparam int NL  = cststf_pkg::NLIMB;
    localparam int NTL = cststf_pkg::NTLIMB;
    localparam int PPW = cststf_pkg::PP_W;

    cststf_pkg::side_t  s5_side_reg;
    logic [DW-1:0]      s5_den_reg;
    logic               s5_neg_reg [NC];
    logic [PPW-1:0]     s5_pp_reg [NC][NL][NTL];

    logic [NL*LW-1:0]   as_pad [NC];

    always_comb begin
        for (int j = 0; j < NC; j++) begin
            as_pad[j] = (NL*LW)'(s4_as_reg[j]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s5_side_reg <= '0;
        end else if (en) begin
            s5_side_reg <= s4_side_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s5_den_reg <= DW'(s4_dlo_reg) + {s4_dhi_reg[DW-HFW-1:0], {HFW{1'b0}}};
            for (int j = 0; j < NC; j++) begin
                s5_neg_reg[j] <= s4_neg_reg[j];
                for (int a = 0; a < NL; a++) begin
                    for (int b = 0; b < NTL; b++) begin
                        s5_pp_reg[j][a][b] <= as_pad[j][a*LW +: LW]
                                            * s4_te_reg[b*TLW +: TLW];
                    end
                end
            end
        end
    end

    // -------------------------------------------- stage 6: numerator sums
    localparam int NW = cststf_pkg::N_W;

    cststf_pkg::side_t s6_side_reg;
    logic [DW-1:0]     s6_den_reg;
    logic              s6_neg_reg [NC];
    logic [NW-1:0]     s6_num_reg [NC];

    logic [NW-1:0]     num_next [NC];

    always_comb begin
        for (int j = 0; j < NC; j++) begin
            num_next[j] = '0;
            for (int a = 0; a < NL; a++) begin
                for (int b = 0; b < NTL; b++) begin
                    num_next[j] = num_next[j] + (NW'(s5_pp_reg[j][a][b]) << (a*LW + b*TLW));
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s6_side_reg <= '0;
        end else if (en) begin
            s6_side_reg <= s5_side_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s6_den_reg <= s5_den_reg;
            for (int j = 0; j < NC; j++) begin
                s6_neg_reg[j] <= s5_neg_reg[j];
                s6_num_reg[j] <= num_next[j];
            end
        end
    end

    // --------------------------------------- dividers, one lane per column
    logic [cststf_pkg::Q_W-1:0] div_val [NC];

    for (genvar j = 0; j < NC; j++) begin : g_lane
        cststf_div u_div (
            .aclk  (aclk),
            .en    (en),
            .num_i (s6_num_reg[j]),
            .den_i (s6_den_reg),
            .neg_i (s6_neg_reg[j]),
            .val_o (div_val[j])
        );
    end

    // row number, valid and area flag follow the divider latency
    cststf_pkg::side_t side_reg [LAT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < LAT; k++) begin
                side_reg[k] <= '0;
            end
        end else if (en) begin
            side_reg[0] <= s6_side_reg;
            for (int k = 1; k < LAT; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_side = side_reg[LAT-1];

    // ------------------------------------------------------------- output
    logic [cststf_pkg::Q_W-1:0] col [NC];

    always_comb begin
        for (int j = 0; j < NC; j++) begin
            col[j] = out_side.degen ? '0 : div_val[j];
        end
    end

    assign m_tvalid = out_side.vld;
    assign m_tdata  = {5'b00000, col[5], col[4], col[3], col[2], col[1], col[0],
                       out_side.row};
    assign m_tlast  = (out_side.row == cststf_pkg::ROW_LAST);
    assign m_tuser  = out_side.degen;

endmodule
`default_nettype wire
